// ===== rtl/core/clipped_alpha_blend_pixel_writer_defines.svh =====
// ----------------------------------------------------------------------------
// clipped alpha blend pixel writer assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef CLIPPED_ALPHA_BLEND_PIXEL_WRITER_DEFINES_SVH
`define CLIPPED_ALPHA_BLEND_PIXEL_WRITER_DEFINES_SVH

// same-cycle implication
`define CABPW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cabpw port check failed");

// next-cycle implication
`define CABPW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cabpw port check failed");

`endif

// ===== rtl/core/cabpw_pkg.sv =====
// ----------------------------------------------------------------------------
// cabpw_pkg
// shared types and constants of the clipped alpha blend pixel writer
// ----------------------------------------------------------------------------
`default_nettype none

package cabpw_pkg;

    localparam int COORD_W     = 16;
    localparam int FRAME_W     = 9;
    localparam int CLIP_SIZE_W = 15;
    localparam int COLOR_W     = 32;
    localparam int CHAN_W      = 8;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 32;
    localparam int OP_W        = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_LEFT    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_TOP     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_WIDTH   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_CLIP_HEIGHT  = 3'd5;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_BLEND = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        logic load_in;
        logic check;
        logic mem_rd;
        logic exec;
        logic clear_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/cabpw_ctrl.sv =====
// ----------------------------------------------------------------------------
// cabpw_ctrl
// sequencer: clear pass, accept, check, read, execute and output handoff
// ----------------------------------------------------------------------------
`default_nettype none

module cabpw_ctrl
    import cabpw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  logic       m_tready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_READ,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   exec_fire;

    assign exec_fire = (state_reg == ST_EXEC) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: state_next = ST_READ;
            ST_READ:  state_next = ST_EXEC;
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        if (exec_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready     = (state_reg == ST_IDLE);
    assign m_tvalid     = out_valid_reg;

    assign cmd.load_in  = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.check    = (state_reg == ST_CHECK);
    assign cmd.mem_rd   = (state_reg == ST_READ);
    assign cmd.exec     = exec_fire;
    assign cmd.clear_wr = (state_reg == ST_CLEAR);

endmodule

`default_nettype wire

// ===== rtl/core/cabpw_datapath.sv =====
// ----------------------------------------------------------------------------
// cabpw_datapath
// config registers, bounds and clip test, address, frame store and blend
// ----------------------------------------------------------------------------
`default_nettype none

module cabpw_datapath
    import cabpw_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [IN_DATA_W-1:0]   s_tdata,
    input  logic [OP_W-1:0]        s_tuser,
    input  dp_cmd_t                cmd,
    output dp_status_t             status,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser
);

    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int FCW    = (WW > FRAME_W) ? WW : FRAME_W;
    localparam int FHW    = (HW > FRAME_W) ? HW : FRAME_W;
    localparam int PW     = YW + WW;
    localparam int CW     = COORD_W + 2;

    function automatic logic [CHAN_W-1:0] mix_channel(
        input logic [CHAN_W-1:0] src,
        input logic [CHAN_W-1:0] old,
        input logic [CHAN_W-1:0] a
    );
        logic [2*CHAN_W-1:0] p_src;
        logic [2*CHAN_W-1:0] p_old;
        p_src = (2*CHAN_W)'(src) * (2*CHAN_W)'(a);
        p_old = (2*CHAN_W)'(old) * (2*CHAN_W)'(ALPHA_OPAQUE - a);
        return p_src[2*CHAN_W-1:CHAN_W] + p_old[2*CHAN_W-1:CHAN_W];
    endfunction

    // config registers
    logic [FRAME_W-1:0]     frame_width_reg;
    logic [FRAME_W-1:0]     frame_height_reg;
    logic [COORD_W-1:0]     clip_left_reg;
    logic [COORD_W-1:0]     clip_top_reg;
    logic [CLIP_SIZE_W-1:0] clip_width_reg;
    logic [CLIP_SIZE_W-1:0] clip_height_reg;

    // item registers
    op_t                    op_reg;
    logic [COORD_W-1:0]     x_reg;
    logic [COORD_W-1:0]     y_reg;
    logic [COLOR_W-1:0]     color_reg;
    logic [CHAN_W-1:0]      a_reg;
    logic [CHAN_W-1:0]      r_reg;
    logic [CHAN_W-1:0]      g_reg;
    logic [CHAN_W-1:0]      b_reg;

    logic [ADDR_W-1:0]      addr_reg;
    logic [ADDR_W-1:0]      addr_next;
    logic                   frame_ok_reg;
    logic                   frame_ok_next;
    logic                   clip_ok_reg;
    logic                   clip_ok_next;
    logic [ADDR_W-1:0]      clr_cnt_reg;
    logic [COLOR_W-1:0]     rd_data_reg;
    logic [OUT_DATA_W-1:0]  pixel_reg;
    logic                   accepted_reg;

    logic [COLOR_W-1:0]     mem [DEPTH];

    logic [FCW-1:0]         fw_ext;
    logic [FHW-1:0]         fh_ext;
    logic [WW-1:0]          eff_w;
    logic [HW-1:0]          eff_h;
    logic                   x_in;
    logic                   y_in;
    logic signed [CW-1:0]   x_s;
    logic signed [CW-1:0]   y_s;
    logic signed [CW-1:0]   left_s;
    logic signed [CW-1:0]   top_s;
    logic signed [CW-1:0]   right_s;
    logic signed [CW-1:0]   bottom_s;
    logic                   clip_off;
    logic [PW-1:0]          prod;

    logic                   rd_ok;
    logic                   wr_ok;
    logic [CHAN_W-1:0]      old_a;
    logic [2*CHAN_W-1:0]    pa;
    logic [CHAN_W-1:0]      new_a;
    logic [COLOR_W-1:0]     blend_val;
    logic [COLOR_W-1:0]     wr_val;
    logic [ADDR_W-1:0]      mem_addr;
    logic                   mem_we;
    logic [COLOR_W-1:0]     mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= 9'd256;
            frame_height_reg <= 9'd256;
            clip_left_reg    <= '0;
            clip_top_reg     <= '0;
            clip_width_reg   <= '0;
            clip_height_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[FRAME_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[FRAME_W-1:0];
                REG_CLIP_LEFT:    clip_left_reg    <= cfg_data;
                REG_CLIP_TOP:     clip_top_reg     <= cfg_data;
                REG_CLIP_WIDTH:   clip_width_reg   <= cfg_data[CLIP_SIZE_W-1:0];
                REG_CLIP_HEIGHT:  clip_height_reg  <= cfg_data[CLIP_SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op_t'(s_tuser);
            x_reg     <= s_tdata[15:0];
            y_reg     <= s_tdata[31:16];
            color_reg <= s_tdata[63:32];
            a_reg     <= s_tdata[71:64];
            r_reg     <= s_tdata[79:72];
            g_reg     <= s_tdata[87:80];
            b_reg     <= s_tdata[95:88];
        end
    end

    // frame size saturates to the store geometry
    assign fw_ext = FCW'(frame_width_reg);
    assign fh_ext = FHW'(frame_height_reg);
    assign eff_w  = (fw_ext > FCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(fw_ext);
    assign eff_h  = (fh_ext > FHW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(fh_ext);

    assign x_in = !x_reg[COORD_W-1] && ({1'b0, x_reg} < (COORD_W+1)'(eff_w));
    assign y_in = !y_reg[COORD_W-1] && ({1'b0, y_reg} < (COORD_W+1)'(eff_h));
    assign frame_ok_next = x_in && y_in;

    // clip edges in a wider signed range so right and bottom cannot wrap
    assign x_s      = CW'($signed(x_reg));
    assign y_s      = CW'($signed(y_reg));
    assign left_s   = CW'($signed(clip_left_reg));
    assign top_s    = CW'($signed(clip_top_reg));
    assign right_s  = left_s + $signed({3'b000, clip_width_reg});
    assign bottom_s = top_s + $signed({3'b000, clip_height_reg});
    assign clip_off = (clip_width_reg == '0) || (clip_height_reg == '0);
    assign clip_ok_next = clip_off ||
        ((x_s >= left_s) && (x_s < right_s) && (y_s >= top_s) && (y_s < bottom_s));

    assign prod      = PW'(y_reg[YW-1:0]) * PW'(eff_w);
    assign addr_next = ADDR_W'(prod) + ADDR_W'(x_reg[XW-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            addr_reg     <= addr_next;
            frame_ok_reg <= frame_ok_next;
            clip_ok_reg  <= clip_ok_next;
        end
    end

    // clear pass counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear_wr)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));

    // execute decode
    assign rd_ok = (op_reg == OP_READ) && frame_ok_reg;
    assign wr_ok = frame_ok_reg && clip_ok_reg &&
        ((op_reg == OP_WRITE) || ((op_reg == OP_BLEND) && (a_reg != '0)));

    assign old_a     = rd_data_reg[31:24];
    assign pa        = (2*CHAN_W)'(ALPHA_OPAQUE - old_a) * (2*CHAN_W)'(a_reg);
    assign new_a     = old_a + pa[2*CHAN_W-1:CHAN_W];
    assign blend_val = (a_reg == ALPHA_OPAQUE) ? {a_reg, r_reg, g_reg, b_reg} :
        {new_a,
         mix_channel(r_reg, rd_data_reg[23:16], a_reg),
         mix_channel(g_reg, rd_data_reg[15:8], a_reg),
         mix_channel(b_reg, rd_data_reg[7:0], a_reg)};
    assign wr_val    = (op_reg == OP_WRITE) ? color_reg : blend_val;

    // single-port frame store
    assign mem_addr  = cmd.clear_wr ? clr_cnt_reg : addr_reg;
    assign mem_we    = cmd.clear_wr || (cmd.exec && wr_ok);
    assign mem_wdata = cmd.clear_wr ? '0 : wr_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            accepted_reg <= rd_ok || wr_ok;
            if (rd_ok)
            begin
                pixel_reg <= rd_data_reg;
            end
            else if (wr_ok)
            begin
                pixel_reg <= wr_val;
            end
            else
            begin
                pixel_reg <= '0;
            end
        end
    end

    assign m_tdata = pixel_reg;
    assign m_tuser = accepted_reg;

endmodule

`default_nettype wire

// ===== rtl/core/clipped_alpha_blend_pixel_writer.sv =====
// ----------------------------------------------------------------------------
// clipped_alpha_blend_pixel_writer
// argb8888 frame store with clipped write, source-over blend and read
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tdata x,y,color,a,r,g,b; tuser operation
//   m_*      out  m_tvalid/m_tready   tdata pixel_value; tuser accepted
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// one word at a time, in turn: accept, bounds/clip and address multiply,
// store read, then execute with the store write on the single memory port
// the execute step registers the output word; the next word is taken in the
// cycle after the execute step, while the output word may still wait
// after reset a clear pass writes zero to all MAX_WIDTH*MAX_HEIGHT words;
// s_tready stays low meanwhile, cfg_ready is always high
// an output stall holds the execute step until the output register frees
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_alpha_blend_pixel_writer
    import cabpw_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // pos_x, pos_y, color_word, alpha_in, red_in, green_in, blue_in
    input  logic [IN_DATA_W-1:0]   s_tdata,
    // operation
    input  logic [OP_W-1:0]        s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // pixel_value
    output logic [OUT_DATA_W-1:0]  m_tdata,
    // accepted
    output logic                   m_tuser,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    cabpw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    cabpw_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/core/cabpw_checker.sv =====
// ----------------------------------------------------------------------------
// cabpw_checker
// port-level checks of the pixel writer, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none
`include "clipped_alpha_blend_pixel_writer_defines.svh"

module cabpw_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic        m_tuser
);

    `CABPW_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    `CABPW_ASSERT_IMP(a_drop_zero, m_tvalid && !m_tuser, m_tdata == 32'd0)
    `CABPW_ASSERT_NXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `CABPW_ASSERT_NXT(a_no_instant_word, s_tvalid && s_tready && !m_tvalid, !m_tvalid)

endmodule

bind clipped_alpha_blend_pixel_writer cabpw_checker u_cabpw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the clipped alpha blend pixel writer: a shadow
// frame store tracks every write and blend, and each output word is compared
// with the predicted accept flag and pixel value across several frame and
// clip settings, with bursty input, a patterned output stall and one long
// output hold-off
// ----------------------------------------------------------------------------

module tb_top;
    import cabpw_pkg::*;

    localparam int MAX_W     = 256;
    localparam int MAX_H     = 256;
    localparam int MEM_WORDS = MAX_W * MAX_H;

    localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [15:0]        x;
        logic [15:0]        y;
        logic [COLOR_W-1:0] color;
        logic [CHAN_W-1:0]  a;
        logic [CHAN_W-1:0]  r;
        logic [CHAN_W-1:0]  g;
        logic [CHAN_W-1:0]  b;
    } pixel_cmd_t;

    typedef struct {
        bit                 accepted;
        bit [COLOR_W-1:0]   pixel;
    } pixel_result_t;

    class pixel_scoreboard;
        bit [COLOR_W-1:0] frame_mem [MEM_WORDS];
        bit [8:0]         frame_width  = 9'd256;
        bit [8:0]         frame_height = 9'd256;
        shortint          clip_left    = 0;
        shortint          clip_top     = 0;
        bit [14:0]        clip_width   = '0;
        bit [14:0]        clip_height  = '0;
        pixel_result_t    expected_pixels [$];
        int               failures     = 0;

        task report(string what);
            if (failures < 50)
                $display("mismatch at %0t: %s", $realtime, what);
            failures++;
        endtask

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [15:0] value);
            case (idx)
                REG_FRAME_WIDTH:  frame_width  = value[8:0];
                REG_FRAME_HEIGHT: frame_height = value[8:0];
                REG_CLIP_LEFT:    clip_left    = value;
                REG_CLIP_TOP:     clip_top     = value;
                REG_CLIP_WIDTH:   clip_width   = value[14:0];
                REG_CLIP_HEIGHT:  clip_height  = value[14:0];
                default: ;
            endcase
        endfunction

        function bit [7:0] blend_channel(bit [7:0] src, bit [7:0] dst, bit [7:0] alpha);
            int unsigned s = src;
            int unsigned d = dst;
            int unsigned al = alpha;
            int unsigned sum;
            sum = ((s * al) >> 8) + ((d * (255 - al)) >> 8);
            return sum[7:0];
        endfunction

        function bit inside_clip(int xi, int yi);
            int cl = clip_left;
            int ct = clip_top;
            int cw = clip_width;
            int ch = clip_height;
            if (cw == 0 || ch == 0)
                return 1'b1;
            return xi >= cl && xi < cl + cw && yi >= ct && yi < ct + ch;
        endfunction

        // predict the output word of one accepted command and update the store
        function void apply_command(pixel_cmd_t c);
            int xi = $signed(c.x);
            int yi = $signed(c.y);
            int w = (frame_width > MAX_W) ? MAX_W : frame_width;
            int h = (frame_height > MAX_H) ? MAX_H : frame_height;
            int addr;
            int unsigned oa;
            int unsigned na;
            int unsigned al;
            bit [COLOR_W-1:0] old;
            pixel_result_t res;
            res.accepted = 1'b0;
            res.pixel = '0;
            if (c.op != OP_UNKNOWN && xi >= 0 && xi < w && yi >= 0 && yi < h) begin
                addr = yi * w + xi;
                if (c.op == OP_READ) begin
                    res.pixel = frame_mem[addr];
                    res.accepted = 1'b1;
                end
                else if (inside_clip(xi, yi)) begin
                    if (c.op == OP_WRITE) begin
                        res.pixel = c.color;
                        res.accepted = 1'b1;
                    end
                    else if (c.a != 8'd0) begin
                        res.accepted = 1'b1;
                        if (c.a == ALPHA_OPAQUE) begin
                            res.pixel = {c.a, c.r, c.g, c.b};
                        end
                        else begin
                            old = frame_mem[addr];
                            oa = old[31:24];
                            al = c.a;
                            na = oa + (((255 - oa) * al) >> 8);
                            res.pixel = {na[7:0],
                                         blend_channel(c.r, old[23:16], c.a),
                                         blend_channel(c.g, old[15:8], c.a),
                                         blend_channel(c.b, old[7:0], c.a)};
                        end
                    end
                    if (res.accepted)
                        frame_mem[addr] = res.pixel;
                end
            end
            expected_pixels.push_back(res);
        endfunction

        task check_output(bit accepted, bit [COLOR_W-1:0] pixel);
            pixel_result_t want;
            if (expected_pixels.size() == 0) begin
                report($sformatf("output word with none pending (acc %0d, pixel %h)",
                                 accepted, pixel));
            end
            else begin
                want = expected_pixels.pop_front();
                if (accepted !== want.accepted)
                    report($sformatf("accepted %0d, want %0d", accepted, want.accepted));
                if (pixel !== want.pixel)
                    report($sformatf("pixel_value %h, want %h", pixel, want.pixel));
            end
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic [OP_W-1:0]        s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    logic hold_recv = 1'b0;
    int   items_sent = 0;
    int   burst_left = 0;
    int   rx_mode = 0;
    int   rx_period = 2;
    int   rx_left = 0;
    int   rx_tick = 0;

    pixel_scoreboard sb;

    clipped_alpha_blend_pixel_writer #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic pixel_cmd_t make_cmd(logic [OP_W-1:0] op, int x, int y,
                                            logic [31:0] color, int a, int r, int g, int b);
        pixel_cmd_t c;
        c.op = op;
        c.x = x[15:0];
        c.y = y[15:0];
        c.color = color;
        c.a = a[7:0];
        c.r = r[7:0];
        c.g = g[7:0];
        c.b = b[7:0];
        return c;
    endfunction

    function automatic logic [15:0] pick_coord(int span);
        int roll = $urandom_range(0, 99);
        int hot = (span < 8) ? span : 8;
        int v;
        if (roll < 45)
            v = $urandom_range(0, hot - 1);
        else if (roll < 75)
            v = $urandom_range(0, span - 1);
        else if (roll < 88)
            case ($urandom_range(0, 3))
                0: v = -1;
                1: v = span;
                2: v = span - 1;
                default: v = 0;
            endcase
        else
            v = $urandom;
        return v[15:0];
    endfunction

    function automatic pixel_cmd_t random_cmd(int span_x, int span_y);
        pixel_cmd_t c;
        int roll = $urandom_range(0, 99);
        int aroll = $urandom_range(0, 99);
        if (roll < 30)
            c.op = OP_WRITE;
        else if (roll < 70)
            c.op = OP_BLEND;
        else if (roll < 95)
            c.op = OP_READ;
        else
            c.op = OP_UNKNOWN;
        c.x = pick_coord(span_x);
        c.y = pick_coord(span_y);
        c.color = $urandom;
        if (aroll < 10)
            c.a = 8'd0;
        else if (aroll < 20)
            c.a = ALPHA_OPAQUE;
        else
            c.a = 8'($urandom_range(0, 255));
        c.r = 8'($urandom);
        c.g = 8'($urandom);
        c.b = 8'($urandom);
        return c;
    endfunction

    task automatic send_cmd(pixel_cmd_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= {c.b, c.g, c.r, c.a, c.color, c.y, c.x};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.apply_command(c);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_random(int span_x, int span_y, int count);
        repeat (count) send_cmd(random_cmd(span_x, span_y));
    endtask

    // drain everything, then write all six registers back to back
    task automatic settle(int w, int h, int cl, int ct, int cw, int ch);
        logic [15:0]            vals [6];
        logic [CFG_INDEX_W-1:0] regs [6];
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        vals = '{w[15:0], h[15:0], cl[15:0], ct[15:0], cw[15:0], ch[15:0]};
        regs = '{REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_CLIP_LEFT,
                 REG_CLIP_TOP, REG_CLIP_WIDTH, REG_CLIP_HEIGHT};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.set_register(regs[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        sb = new;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        settle(256, 256, 0, 0, 0, 0);
        send_cmd(make_cmd(OP_WRITE, 0, 0, 32'hffffffff, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 255, 255, 32'h5a5aa5a5, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 255, 255, 0, 0, 0, 0, 0));
        // zero alpha is dropped
        send_cmd(make_cmd(OP_BLEND, 1, 1, 0, 0, 255, 255, 255));
        send_cmd(make_cmd(OP_BLEND, 1, 1, 0, 255, 8'h12, 8'h34, 8'h56));
        send_cmd(make_cmd(OP_BLEND, 1, 1, 0, 128, 255, 0, 128));
        send_cmd(make_cmd(OP_BLEND, 0, 0, 0, 1, 0, 0, 0));
        send_cmd(make_cmd(OP_BLEND, 0, 0, 0, 254, 255, 255, 255));
        send_cmd(make_cmd(OP_BLEND, 2, 2, 32'hffffffff, 100, 200, 50, 255));
        // outside the frame
        send_cmd(make_cmd(OP_READ, 256, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 256, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, -1, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, -1, 5, 32'hffffffff, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 5, -32768, 32'hffffffff, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 32767, 32767, 32'hffffffff, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_BLEND, -32768, -32768, 0, 128, 255, 255, 255));
        // unknown operation does nothing
        send_cmd(make_cmd(OP_UNKNOWN, 3, 3, 32'hffffffff, 255, 255, 255, 255));
        send_cmd(make_cmd(OP_READ, 3, 3, 32'hffffffff, 255, 255, 255, 255));
        send_cmd(make_cmd(OP_READ, 1, 1, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_WRITE, 255, 0, 32'h80000001, 255, 255, 255, 255));
        send_cmd(make_cmd(OP_READ, 255, 0, 0, 0, 0, 0, 0));
        send_random(256, 256, 115);

        settle(1, 1, 0, 0, 0, 0);
        send_random(1, 1, 135);
        settle(16, 8, 4, 2, 6, 3);
        send_random(16, 8, 135);
        settle(256, 256, -32768, -32768, 32767, 32767);
        send_random(256, 256, 135);
        // zero clip height falls back to the frame
        settle(37, 200, -5, 10, 20, 0);
        send_random(37, 200, 135);
        settle(256, 3, 250, 1, 10, 1);
        send_random(256, 3, 135);
        settle(5, 256, 32767, 32767, 1, 1);
        send_random(5, 256, 135);
        settle(200, 256, 0, 0, 32767, 32767);
        send_random(200, 256, 135);

        s_tvalid <= 1'b0;
        while (sb.expected_pixels.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.failures == 0)
            $display("clipped_alpha_blend_pixel_writer regression: pass");
        else
            $display("clipped_alpha_blend_pixel_writer regression: fail");
        $finish;
    end

    // output side: check every transferred word and stall on a changing pattern
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_output(m_tuser, m_tdata);
            if (rx_left == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_period = $urandom_range(2, 9);
                rx_left = $urandom_range(20, 120);
                rx_tick = 0;
            end
            rx_left--;
            rx_tick++;
            case (rx_mode)
                0: m_tready <= !hold_recv;
                1: m_tready <= !hold_recv && ($urandom_range(0, 1) == 1);
                2: m_tready <= !hold_recv && ((rx_tick % rx_period) != 0);
                default: m_tready <= !hold_recv && ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // long output hold-off while input keeps coming
    initial
    begin
        wait (items_sent >= 400);
        @(posedge clk);
        hold_recv <= 1'b1;
        repeat (300) @(posedge clk);
        hold_recv <= 1'b0;
    end

    initial
    begin
        #8000000;
        $display("clipped_alpha_blend_pixel_writer regression: fail");
        $finish;
    end

endmodule
